[rtl/core/lwd_pkg.sv]
`timescale 1ns / 1ps
// lwd_pkg: shared types, codes and constants for the liveness watchdog.
// No dependencies; imported by every module of the block.
package lwd_pkg;

    // Configuration port geometry (64-bit registers at 8-byte strides)
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    // Default number of watched channels
    localparam int CHANNELS_DEF = 8;
    localparam int MASK_W       = 8;

    // Register indexes (paddr[4:3])
    localparam logic [1:0] REG_AUTO_RESTART = 2'd0;
    localparam logic [1:0] REG_STALE_G0     = 2'd1;
    localparam logic [1:0] REG_STALE_G1     = 2'd2;

    // Reset thresholds in ms: ch0..3 = 200,100,100,1000; ch4..7 = 500,5000,100,2000
    localparam logic [63:0] STALE_G0_RST = 64'h03E8_0064_0064_00C8;
    localparam logic [63:0] STALE_G1_RST = 64'h07D0_0064_1388_01F4;

    // Threshold scaling: 16-bit ms times 1000 fits in 26 bits
    localparam int          STALE_MS_W = 16;
    localparam int          STALE_US_W = 26;
    localparam logic [9:0]  US_PER_MS  = 10'd1000;

    // Item action codes
    localparam logic [1:0] ACT_POLL    = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_CRASH   = 2'd2;

    // Result event codes
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_ALIVE = 2'd1;
    localparam logic [1:0] EV_DEAD  = 2'd2;

    // Configuration values handed from the register file to the datapath
    typedef struct packed {
        logic [MASK_W-1:0] auto_restart_mask;
        logic [63:0]       stale_g0;
        logic [63:0]       stale_g1;
    } lwd_cfg_t;

endpackage

[rtl/core/multi_channel_liveness_watchdog_top.sv]
`timescale 1ns / 1ps
// Liveness watchdog top: input register, per-channel state table and result register.
// Items pass through the input register, then the result register; out_stall holds both.
// Throughput: one item per cycle if unstalled; per-channel state is read and written in one pass.
// Reset (rst_n, async): all channel state, counters and valids clear; thresholds take defaults.
// Items naming a channel at or above CHANNELS are dropped at the input and give no result.
// Depends on lwd_pkg and lwd_cfg.
module multi_channel_liveness_watchdog_top
    import lwd_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [2:0]        channel,
    input  logic [63:0]       now_us,
    input  logic [63:0]       beat_us,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        out_channel,
    output logic [1:0]        event_res,
    output logic              alive,
    output logic              ever_alive,
    output logic [63:0]       age_us,
    output logic [63:0]       last_heartbeat_us,
    output logic              restart_request,
    output logic              recovered,
    output logic [31:0]       restarts,
    output logic [31:0]       crashes
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    lwd_cfg_t cfg;

    lwd_cfg u_lwd_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ---------------- input stage ----------------
    logic                  s1_valid_reg, s1_valid_next;
    logic [1:0]            s1_action_reg;
    logic [2:0]            s1_chan_reg;
    logic [63:0]           s1_now_reg;
    logic [63:0]           s1_cl_reg;
    logic                  s1_sig_nz_reg;
    logic [STALE_US_W-1:0] s1_stale_reg;

    logic                  s1_advance;
    logic                  in_load;
    logic                  chan_ok;
    logic [63:0]           in_grp;
    logic [STALE_MS_W-1:0] in_ms;
    logic [STALE_US_W-1:0] in_stale;
    logic [63:0]           in_cl;

    assign s1_advance = !out_valid || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_load    = in_valid && !in_stall;
    assign chan_ok    = {1'b0, channel} < 4'(CHANNELS);

    // Threshold lookup and clamp of the heartbeat to now
    assign in_grp   = channel[2] ? cfg.stale_g1 : cfg.stale_g0;
    assign in_ms    = in_grp[channel[1:0]*STALE_MS_W +: STALE_MS_W];
    assign in_stale = STALE_US_W'(in_ms) * STALE_US_W'(US_PER_MS);
    assign in_cl    = (beat_us > now_us) ? now_us : beat_us;

    always_comb
    begin
        if (in_load)
            s1_valid_next = chan_ok;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            s1_action_reg <= action;
            s1_chan_reg   <= channel;
            s1_now_reg    <= now_us;
            s1_cl_reg     <= in_cl;
            s1_sig_nz_reg <= (beat_us != 64'd0);
            s1_stale_reg  <= in_stale;
        end
    end

    // ---------------- channel state table ----------------
    logic [63:0] hb_reg      [CHANNELS];
    logic        alive_reg   [CHANNELS];
    logic        ever_reg    [CHANNELS];
    logic        interv_reg  [CHANNELS];
    logic [31:0] restart_reg [CHANNELS];
    logic [31:0] crash_reg   [CHANNELS];

    logic [CH_IDX_W-1:0] idx;
    logic                commit;
    logic                is_poll;
    logic [63:0]         last_cur;
    logic                upd;
    logic [63:0]         new_last;
    logic [63:0]         d_cl;
    logic [63:0]         d_last;
    logic                last_ge_now;
    logic                alive_cl;
    logic                alive_last;
    logic                alive_now;
    logic                alive_prev;
    logic                new_alive;
    logic                new_ever;
    logic                new_interv;
    logic [31:0]         new_restarts;
    logic [31:0]         new_crashes;
    logic [1:0]          ev;
    logic                req;
    logic                rec;
    logic [63:0]         age;

    assign idx      = s1_chan_reg[CH_IDX_W-1:0];
    assign commit   = s1_valid_reg && s1_advance;
    assign is_poll  = (s1_action_reg == ACT_POLL);
    assign last_cur = hb_reg[idx];

    // Poll evaluation: both candidate heartbeats are judged in parallel
    assign upd         = s1_sig_nz_reg && (s1_cl_reg > last_cur);
    assign new_last    = upd ? s1_cl_reg : last_cur;
    assign d_cl        = s1_now_reg - s1_cl_reg;
    assign d_last      = s1_now_reg - last_cur;
    assign last_ge_now = (last_cur >= s1_now_reg);
    assign alive_cl    = (d_cl <= 64'(s1_stale_reg));
    assign alive_last  = (last_cur != 64'd0)
                         && (last_ge_now || (d_last <= 64'(s1_stale_reg)));
    assign alive_now   = upd ? alive_cl : alive_last;
    assign alive_prev  = alive_reg[idx];

    // Next state and result fields for the item in the input stage
    always_comb
    begin
        new_alive    = alive_prev;
        new_ever     = ever_reg[idx];
        new_interv   = interv_reg[idx];
        new_restarts = restart_reg[idx];
        new_crashes  = crash_reg[idx];
        ev           = EV_NONE;
        req          = 1'b0;
        rec          = 1'b0;
        age          = 64'd0;
        case (s1_action_reg)
            ACT_POLL:
            begin
                new_alive = alive_now;
                new_ever  = ever_reg[idx] || upd;
                if (!alive_prev && alive_now)
                begin
                    ev  = EV_ALIVE;
                    rec = interv_reg[idx];
                end
                else if (alive_prev && !alive_now)
                begin
                    ev  = EV_DEAD;
                    req = cfg.auto_restart_mask[s1_chan_reg];
                end
                if (upd)
                    age = d_cl;
                else if (last_cur == 64'd0)
                    age = '1;
                else if (last_ge_now)
                    age = 64'd0;
                else
                    age = d_last;
            end
            ACT_RESTART:
            begin
                new_restarts = restart_reg[idx] + 32'd1;
                new_interv   = 1'b1;
            end
            ACT_CRASH:
            begin
                new_crashes = crash_reg[idx] + 32'd1;
                new_interv  = 1'b1;
            end
            default: ;
        endcase
    end

    // State write-back as the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                hb_reg[i]      <= '0;
                alive_reg[i]   <= 1'b0;
                ever_reg[i]    <= 1'b0;
                interv_reg[i]  <= 1'b0;
                restart_reg[i] <= '0;
                crash_reg[i]   <= '0;
            end
        end
        else if (commit)
        begin
            if (is_poll)
                hb_reg[idx] <= new_last;
            alive_reg[idx]   <= new_alive;
            ever_reg[idx]    <= new_ever;
            interv_reg[idx]  <= new_interv;
            restart_reg[idx] <= new_restarts;
            crash_reg[idx]   <= new_crashes;
        end
    end

    // ---------------- result register ----------------
    logic out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_channel       <= s1_chan_reg;
            event_res         <= ev;
            alive             <= new_alive;
            ever_alive        <= new_ever;
            age_us            <= age;
            last_heartbeat_us <= is_poll ? new_last : last_cur;
            restart_request   <= req;
            recovered         <= rec;
            restarts          <= new_restarts;
            crashes           <= new_crashes;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[rtl/core/lwd_cfg.sv]
`timescale 1ns / 1ps
// lwd_cfg: APB-style configuration registers of the liveness watchdog.
// Depends on lwd_pkg.
module lwd_cfg
    import lwd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output lwd_cfg_t          cfg
);

    logic [MASK_W-1:0] mask_reg;
    logic [63:0]       stale_g0_reg;
    logic [63:0]       stale_g1_reg;
    logic [1:0]        reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= '0;
            stale_g0_reg <= STALE_G0_RST;
            stale_g1_reg <= STALE_G1_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_AUTO_RESTART: mask_reg     <= pwdata[MASK_W-1:0];
                REG_STALE_G0:     stale_g0_reg <= pwdata;
                REG_STALE_G1:     stale_g1_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_AUTO_RESTART: prdata = {{(DATA_W-MASK_W){1'b0}}, mask_reg};
            REG_STALE_G0:     prdata = stale_g0_reg;
            REG_STALE_G1:     prdata = stale_g1_reg;
            default:          prdata = '0;
        endcase
    end

    assign cfg.auto_restart_mask = mask_reg;
    assign cfg.stale_g0          = stale_g0_reg;
    assign cfg.stale_g1          = stale_g1_reg;

endmodule

[rtl/core/lwd_checker.sv]
`timescale 1ns / 1ps
// lwd_checker: port-level assertions for the liveness watchdog, and its bind.
// Depends on lwd_pkg; attaches to multi_channel_liveness_watchdog_top.
module lwd_checker
    import lwd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  out_channel,
    input logic [1:0]  event_res,
    input logic        alive,
    input logic        ever_alive,
    input logic [63:0] age_us,
    input logic [63:0] last_heartbeat_us,
    input logic        restart_request,
    input logic        recovered
);

    // A stalled result stays presented, with its channel and age unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_channel)
                                   && $stable(age_us))
        else $error("result changed while stalled");

    // Edge events agree with the reported alive state
    a_edge_alive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_ALIVE || event_res == EV_DEAD)
        |-> alive == (event_res == EV_ALIVE))
        else $error("edge event disagrees with alive");

    // Restart requests only on dead edges, recoveries only on alive edges
    a_req_rec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (restart_request || recovered)
        |-> (restart_request && !recovered && event_res == EV_DEAD)
            || (recovered && !restart_request && event_res == EV_ALIVE))
        else $error("restart request or recovery without matching edge");

    // An alive channel has a stored heartbeat
    a_alive_hb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alive |-> ever_alive && last_heartbeat_us != 64'd0)
        else $error("alive without heartbeat");

    // An all-ones age means no heartbeat has been stored
    a_age_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && age_us == '1 |-> last_heartbeat_us == 64'd0 && !alive)
        else $error("age all ones with a stored heartbeat");

endmodule

bind multi_channel_liveness_watchdog_top lwd_checker u_lwd_checker (.*);
